FILE: design/ctenp_pkg.sv
// Shared constants, command codes and the command type of the console token editor.
`timescale 1ns / 1ps
package ctenp_pkg;

    localparam int TOKEN_CAPACITY = 32;
    localparam int TOK_DEPTH      = TOKEN_CAPACITY - 1;
    localparam int IDX_W          = $clog2(TOKEN_CAPACITY);
    localparam int CMDQ_DEPTH     = 4;
    localparam int QP_W           = $clog2(CMDQ_DEPTH);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [1:0] CONV_SDEC   = 2'd0;
    localparam logic [1:0] CONV_UDEC   = 2'd1;
    localparam logic [1:0] CONV_HEX    = 2'd2;
    localparam logic [1:0] CONV_SINGLE = 2'd3;

    // commands from front to back
    localparam logic [1:0] OP_STORE  = 2'd0;  // store ch at len, echo it
    localparam logic [1:0] OP_ERASE  = 2'd1;  // echo BS SP BS
    localparam logic [1:0] OP_LINE   = 2'd2;  // echo CR LF, parse len bytes
    localparam logic [1:0] OP_SINGLE = 2'd3;  // echo ch, finish with ch

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       ch;
        logic [IDX_W-1:0] len;
        logic [1:0]       conv;
    } t_cmd;

endpackage

FILE: design/ctenp_front.sv
// Front end: classifies received bytes, tracks token length and mode, issues commands.
`timescale 1ns / 1ps
module ctenp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_char,
    input  logic [1:0]          i_conversion,
    input  logic                i_q_full,
    output logic                o_full,
    output logic                o_q_push,
    output ctenp_pkg::t_cmd     o_q_cmd
);

    logic                        r_collecting, n_collecting;
    logic [ctenp_pkg::IDX_W-1:0] r_len, n_len;
    logic [1:0]                  r_conv, n_conv;

    logic                        accept;
    logic                        blank;
    logic [ctenp_pkg::IDX_W-1:0] eff_len;
    logic [1:0]                  eff_conv;

    assign o_full = i_q_full;
    assign accept = i_valid && !i_q_full;
    assign blank  = (i_rx_char == ctenp_pkg::CH_SP) || (i_rx_char == ctenp_pkg::CH_TAB) ||
                    (i_rx_char == ctenp_pkg::CH_CR) || (i_rx_char == ctenp_pkg::CH_LF);
    // a new token starts with an empty buffer and the mode sampled now
    assign eff_len  = r_collecting ? r_len : '0;
    assign eff_conv = r_collecting ? r_conv : i_conversion;

    always_comb begin
        n_collecting = r_collecting;
        n_len        = r_len;
        n_conv       = r_conv;
        o_q_push     = 1'b0;
        o_q_cmd.op   = ctenp_pkg::OP_STORE;
        o_q_cmd.ch   = i_rx_char;
        o_q_cmd.len  = eff_len;
        o_q_cmd.conv = eff_conv;
        if (accept && !(!r_collecting && blank)) begin
            n_conv = eff_conv;
            if (!r_collecting && eff_conv == ctenp_pkg::CONV_SINGLE) begin
                o_q_push   = 1'b1;
                o_q_cmd.op = ctenp_pkg::OP_SINGLE;
            end else begin
                n_collecting = 1'b1;
                n_len        = eff_len;
                if (i_rx_char == ctenp_pkg::CH_CR || i_rx_char == ctenp_pkg::CH_LF) begin
                    o_q_push     = 1'b1;
                    o_q_cmd.op   = ctenp_pkg::OP_LINE;
                    n_collecting = 1'b0;
                end else if (i_rx_char == ctenp_pkg::CH_BS || i_rx_char == ctenp_pkg::CH_DEL) begin
                    if (eff_len != '0) begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = ctenp_pkg::OP_ERASE;
                        n_len      = eff_len - 1'b1;
                    end
                end else if (i_rx_char >= ctenp_pkg::CH_SP && i_rx_char < ctenp_pkg::CH_DEL &&
                             eff_len < ctenp_pkg::IDX_W'(ctenp_pkg::TOK_DEPTH)) begin
                    o_q_push   = 1'b1;
                    o_q_cmd.op = ctenp_pkg::OP_STORE;
                    n_len      = eff_len + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_len        <= '0;
            r_conv       <= ctenp_pkg::CONV_SDEC;
        end else begin
            r_collecting <= n_collecting;
            r_len        <= n_len;
            r_conv       <= n_conv;
        end
    end

endmodule

FILE: design/ctenp_cmd_q.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module ctenp_cmd_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ctenp_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output ctenp_pkg::t_cmd o_cmd,
    output logic            o_empty
);

    ctenp_pkg::t_cmd             r_q [ctenp_pkg::CMDQ_DEPTH];
    logic [ctenp_pkg::QP_W-1:0]  r_wr, r_rd;
    logic [ctenp_pkg::QP_W:0]    r_cnt;
    logic                        do_push, do_pop;

    assign o_full  = (r_cnt == (ctenp_pkg::QP_W + 1)'(ctenp_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: design/ctenp_back.sv
// Back end: token buffer, echo sequencer, serial token parser and result register.
`timescale 1ns / 1ps
module ctenp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctenp_pkg::t_cmd i_q_cmd,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic            o_kind,
    output logic [7:0]      o_echo_char,
    output logic [31:0]     o_value,
    output logic            o_matched,
    output logic            o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_ST   = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0]                  r_state, n_state;
    ctenp_pkg::t_cmd             r_cmd;
    logic [1:0]                  r_step;
    logic [7:0]                  r_mem [ctenp_pkg::TOK_DEPTH];
    logic [7:0]                  r_rd_data;
    logic [ctenp_pkg::IDX_W-1:0] r_pos;
    logic [31:0]                 r_acc;
    logic                        r_bad, r_has, r_neg, r_first_zero;
    logic                        r_o_valid;

    logic        em_vld, em_kind, em_ok, em_last, em_fire;
    logic [7:0]  em_ch;
    logic [31:0] em_val;
    logic        tok_ok;
    logic [7:0]  c;
    logic        is_dec, is_lhex, is_uhex;
    logic [3:0]  hex_d;
    logic [31:0] acc_dec;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty = !r_o_valid;
    assign tok_ok  = !r_bad && r_has;

    // parse step decode
    assign c       = r_rd_data;
    assign is_dec  = (c >= ctenp_pkg::CH_ZERO) && (c <= ctenp_pkg::CH_NINE);
    assign is_lhex = (c >= ctenp_pkg::CH_LA) && (c <= ctenp_pkg::CH_LF_HEX);
    assign is_uhex = (c >= ctenp_pkg::CH_UA) && (c <= ctenp_pkg::CH_UF);
    assign hex_d   = is_dec ? c[3:0] : c[3:0] + 4'd9;
    assign acc_dec = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, c[3:0]};

    always_comb begin
        em_vld  = 1'b0;
        em_kind = 1'b0;
        em_ch   = 8'd0;
        em_val  = 32'd0;
        em_ok   = 1'b0;
        em_last = 1'b0;
        case (r_state)
            S_EMIT: begin
                em_vld = 1'b1;
                case (r_cmd.op)
                    ctenp_pkg::OP_STORE: begin
                        em_ch   = r_cmd.ch;
                        em_last = 1'b1;
                    end
                    ctenp_pkg::OP_ERASE: begin
                        em_ch   = (r_step == 2'd1) ? ctenp_pkg::CH_SP : ctenp_pkg::CH_BS;
                        em_last = (r_step == 2'd2);
                    end
                    ctenp_pkg::OP_SINGLE: begin
                        if (r_step == 2'd0) begin
                            em_ch = r_cmd.ch;
                        end else begin
                            em_kind = 1'b1;
                            em_val  = {24'd0, r_cmd.ch};
                            em_ok   = 1'b1;
                            em_last = 1'b1;
                        end
                    end
                    ctenp_pkg::OP_LINE: begin
                        em_ch = (r_step == 2'd0) ? ctenp_pkg::CH_CR : ctenp_pkg::CH_LF;
                    end
                    default: begin
                        em_last = 1'b1;
                    end
                endcase
            end
            S_RES: begin
                em_vld  = 1'b1;
                em_kind = 1'b1;
                em_ok   = tok_ok;
                em_val  = tok_ok ? (r_neg ? 32'd0 - r_acc : r_acc) : 32'd0;
                em_last = 1'b1;
            end
            default: begin
                em_vld = 1'b0;
            end
        endcase
    end

    assign em_fire = em_vld && (!r_o_valid || i_pop);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (em_fire) begin
                    if (em_last) begin
                        n_state = S_IDLE;
                    end else if (r_cmd.op == ctenp_pkg::OP_LINE && r_step == 2'd1) begin
                        n_state = (r_cmd.len == '0) ? S_RES : S_RD;
                    end
                end
            end
            S_RD: n_state = S_ST;
            S_ST: n_state = ((r_pos + 1'b1) == r_cmd.len) ? S_RES : S_RD;
            S_RES: begin
                if (em_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (em_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // token buffer
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.op == ctenp_pkg::OP_STORE) begin
            r_mem[i_q_cmd.len] <= i_q_cmd.ch;
        end
        r_rd_data <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_cmd;
            r_step <= 2'd0;
        end
        if (r_state == S_EMIT && em_fire) begin
            r_step <= r_step + 1'b1;
        end
        if (r_state == S_EMIT) begin
            r_pos        <= '0;
            r_acc        <= 32'd0;
            r_bad        <= 1'b0;
            r_has        <= 1'b0;
            r_neg        <= 1'b0;
            r_first_zero <= 1'b0;
        end
        if (r_state == S_ST) begin
            r_pos <= r_pos + 1'b1;
            if (r_pos == '0) begin
                r_first_zero <= (c == ctenp_pkg::CH_ZERO);
            end
            if (r_cmd.conv == ctenp_pkg::CONV_SDEC && r_pos == '0 &&
                c == ctenp_pkg::CH_MINUS) begin
                r_neg <= 1'b1;
            end else if (r_cmd.conv == ctenp_pkg::CONV_HEX &&
                         r_pos == ctenp_pkg::IDX_W'(1) && r_first_zero &&
                         (c == ctenp_pkg::CH_LX || c == ctenp_pkg::CH_UX)) begin
                // 0x prefix: the leading zero was not a digit after all
                r_has <= 1'b0;
                r_acc <= 32'd0;
            end else if (r_cmd.conv == ctenp_pkg::CONV_SDEC ||
                         r_cmd.conv == ctenp_pkg::CONV_UDEC) begin
                if (is_dec) begin
                    r_acc <= acc_dec;
                    r_has <= 1'b1;
                end else begin
                    r_bad <= 1'b1;
                end
            end else begin
                if (is_dec || is_lhex || is_uhex) begin
                    r_acc <= {r_acc[27:0], hex_d};
                    r_has <= 1'b1;
                end else begin
                    r_bad <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            o_kind      <= em_kind;
            o_echo_char <= em_ch;
            o_value     <= em_val;
            o_matched   <= em_ok;
            o_last      <= em_last;
        end
    end

    a_finish_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_kind) |-> o_last)
        else $error("finished conversion not marked last");

    a_echo_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_kind) |-> (!o_matched && o_value == 32'd0))
        else $error("echo request carries value or match");

    a_walk_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST) |-> (r_pos < r_cmd.len))
        else $error("parser walked past token end");

    a_cmd_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_EMIT))
        else $error("command taken without starting emission");

endmodule

FILE: design/console_token_editor_number_parser.sv
// Top level of the console line editor with decimal and hex number parser.
//
//  channel   handshake        payload
//  input     push / full      i_rx_char, i_conversion
//  result    empty / pop      o_kind, o_echo_char, o_value, o_matched, o_last
//
// A byte is taken while not full and turned into at most one command; a 4-deep
// command queue decouples intake from the back end, so full rises only when it fills.
// The back end pops a command, then emits one result request per cycle while pop
// keeps up: the echoed byte for a store, BS SP BS for an erase, the echo and result
// for a single. A line end emits CR and LF, then does a buffer read and a parse step
// per byte, then emits the result. An unpopped result stalls the back end.
// Reset is synchronous; it empties the queue and result register and ends any token.
`timescale 1ns / 1ps
module console_token_editor_number_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_char,
    input  logic [1:0]  i_conversion,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_echo_char,
    output logic [31:0] o_value,
    output logic        o_matched,
    output logic        o_last
);

    ctenp_pkg::t_cmd f_cmd, q_cmd;
    logic            f_push, q_full, q_empty, q_pop;

    ctenp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (push),
        .i_rx_char    (i_rx_char),
        .i_conversion (i_conversion),
        .i_q_full     (q_full),
        .o_full       (full),
        .o_q_push     (f_push),
        .o_q_cmd      (f_cmd)
    );

    ctenp_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    ctenp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_cmd     (q_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_echo_char (o_echo_char),
        .o_value     (o_value),
        .o_matched   (o_matched),
        .o_last      (o_last)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the console token editor and number parser.
`timescale 1ns / 1ps
module testbench;

    localparam int          ITEM_TARGET   = 410;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          MAX_REPORTS   = 10;
    localparam logic        KIND_ECHO     = 1'b0;
    localparam logic        KIND_DONE     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo;
        logic [31:0] value;
        logic        matched;
        logic        last;
    } t_line_result;

    // Tracks the editor state and the echo/finish requests each byte must produce.
    class t_token_scoreboard;
        logic         collecting;
        int           tok_len;
        logic [7:0]   tok_buf [ctenp_pkg::TOK_DEPTH];
        logic [1:0]   conv_held;
        t_line_result expected_q[$];
        int errors, results_seen, chars_seen, chars_active;
        int lines_done, lines_matched, drops, erases, singles;

        function new();
            collecting = 1'b0;
            tok_len    = 0;
            conv_held  = ctenp_pkg::CONV_SDEC;
            foreach (tok_buf[i]) tok_buf[i] = 8'h00;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void expect_result(logic kind, logic [7:0] ch, logic [31:0] v, logic ok,
                                    logic fin);
            t_line_result r;
            r = {kind, ch, v, ok, fin};
            expected_q.push_back(r);
        endfunction

        function logic parse_decimal(int from, output logic [31:0] v);
            logic [31:0] acc;
            acc = 32'd0;
            v   = 32'd0;
            if (from >= tok_len) return 1'b0;
            for (int i = from; i < tok_len; i++) begin
                if (tok_buf[i] < ctenp_pkg::CH_ZERO || tok_buf[i] > ctenp_pkg::CH_NINE)
                    return 1'b0;
                acc = acc * 32'd10 + 32'(tok_buf[i] - ctenp_pkg::CH_ZERO);
            end
            v = acc;
            return 1'b1;
        endfunction

        function logic scan_hex_token(output logic [31:0] v);
            logic [31:0] acc;
            logic [7:0]  c, d;
            int          i;
            acc = 32'd0;
            v   = 32'd0;
            i   = 0;
            if (tok_len >= 2 && tok_buf[0] == ctenp_pkg::CH_ZERO &&
                (tok_buf[1] == ctenp_pkg::CH_LX || tok_buf[1] == ctenp_pkg::CH_UX)) i = 2;
            if (i >= tok_len) return 1'b0;
            for (; i < tok_len; i++) begin
                c = tok_buf[i];
                if (c >= ctenp_pkg::CH_ZERO && c <= ctenp_pkg::CH_NINE)
                    d = c - ctenp_pkg::CH_ZERO;
                else if (c >= ctenp_pkg::CH_LA && c <= ctenp_pkg::CH_LF_HEX)
                    d = c - ctenp_pkg::CH_LA + 8'd10;
                else if (c >= ctenp_pkg::CH_UA && c <= ctenp_pkg::CH_UF)
                    d = c - ctenp_pkg::CH_UA + 8'd10;
                else return 1'b0;
                acc = {acc[27:0], d[3:0]};
            end
            v = acc;
            return 1'b1;
        endfunction

        function logic parse_line(output logic [31:0] v);
            logic ok, neg;
            case (conv_held)
                ctenp_pkg::CONV_SDEC: begin
                    neg = tok_len > 0 && tok_buf[0] == ctenp_pkg::CH_MINUS;
                    ok  = parse_decimal(neg ? 1 : 0, v);
                    if (ok && neg) v = 32'd0 - v;
                end
                ctenp_pkg::CONV_UDEC: ok = parse_decimal(0, v);
                default:              ok = scan_hex_token(v);
            endcase
            return ok;
        endfunction

        function void note_char(logic [7:0] c, logic [1:0] conv);
            logic [31:0] v;
            logic        ok;
            chars_seen++;
            if (!collecting) begin
                if (c == ctenp_pkg::CH_SP || c == ctenp_pkg::CH_TAB ||
                    c == ctenp_pkg::CH_CR || c == ctenp_pkg::CH_LF) return;
                conv_held = conv;
                if (conv == ctenp_pkg::CONV_SINGLE) begin
                    expect_result(KIND_ECHO, c, 32'd0, 1'b0, 1'b0);
                    expect_result(KIND_DONE, 8'h00, {24'd0, c}, 1'b1, 1'b1);
                    singles++;
                    chars_active++;
                    return;
                end
                collecting = 1'b1;
                tok_len    = 0;
            end
            if (c == ctenp_pkg::CH_CR || c == ctenp_pkg::CH_LF) begin
                ok = parse_line(v);
                expect_result(KIND_ECHO, ctenp_pkg::CH_CR, 32'd0, 1'b0, 1'b0);
                expect_result(KIND_ECHO, ctenp_pkg::CH_LF, 32'd0, 1'b0, 1'b0);
                expect_result(KIND_DONE, 8'h00, v, ok, 1'b1);
                collecting = 1'b0;
                lines_done++;
                if (ok) lines_matched++;
                chars_active++;
            end else if (c == ctenp_pkg::CH_BS || c == ctenp_pkg::CH_DEL) begin
                if (tok_len > 0) begin
                    tok_len--;
                    expect_result(KIND_ECHO, ctenp_pkg::CH_BS, 32'd0, 1'b0, 1'b0);
                    expect_result(KIND_ECHO, ctenp_pkg::CH_SP, 32'd0, 1'b0, 1'b0);
                    expect_result(KIND_ECHO, ctenp_pkg::CH_BS, 32'd0, 1'b0, 1'b1);
                    erases++;
                    chars_active++;
                end
            end else if (c >= ctenp_pkg::CH_SP && c < ctenp_pkg::CH_DEL) begin
                if (tok_len < ctenp_pkg::TOK_DEPTH) begin
                    tok_buf[tok_len] = c;
                    tok_len++;
                    expect_result(KIND_ECHO, c, 32'd0, 1'b0, 1'b1);
                    chars_active++;
                end else begin
                    drops++;
                end
            end
        endfunction

        function void check_result(t_line_result got);
            t_line_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: kind %0d echo %02h value %08h matched %0d %s %0d",
                             got.kind, got.echo, got.value, got.matched, "last", got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.echo !== want.echo || got.value !== want.value ||
                got.matched !== want.matched || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("result %0d mismatch (exp/got): kind %0d/%0d echo %02h/%02h",
                             results_seen, want.kind, got.kind, want.echo, got.echo);
                    $display("    value %08h/%08h matched %0d/%0d last %0d/%0d",
                             want.value, got.value, want.matched, got.matched,
                             want.last, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_char;
    logic [1:0]  i_conversion;
    logic        empty;
    logic        pop;
    logic        o_kind;
    logic [7:0]  o_echo_char;
    logic [31:0] o_value;
    logic        o_matched;
    logic        o_last;

    t_token_scoreboard sb;
    int unsigned       send_gap_max = 14;
    int unsigned       take_gap_max = 14;
    bit                hold_results = 1'b0;

    always #2 i_clk = ~i_clk;

    console_token_editor_number_parser u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_char    (i_rx_char),
        .i_conversion (i_conversion),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_echo_char  (o_echo_char),
        .o_value      (o_value),
        .o_matched    (o_matched),
        .o_last       (o_last)
    );

    task automatic send_char(input logic [7:0] c, input logic [1:0] conv);
        int unsigned gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap != 0) begin
            push         <= 1'b0;
            i_rx_char    <= 8'($urandom);
            i_conversion <= 2'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_rx_char    <= c;
        i_conversion <= conv;
        do @(posedge i_clk); while (full);
        sb.note_char(c, conv);
    endtask

    task automatic send_str(input string s, input logic [1:0] conv);
        for (int i = 0; i < s.len(); i++) send_char(s[i], conv);
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3, 0))
            0:       return ctenp_pkg::CH_SP;
            1:       return ctenp_pkg::CH_TAB;
            2:       return ctenp_pkg::CH_CR;
            default: return ctenp_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit(logic [1:0] mode);
        logic [7:0] d;
        if (mode != ctenp_pkg::CONV_HEX)
            return ctenp_pkg::CH_ZERO + 8'($urandom_range(9, 0));
        d = 8'($urandom_range(15, 0));
        if (d < 8'd10) return ctenp_pkg::CH_ZERO + d;
        return ($urandom_range(1, 0) ? ctenp_pkg::CH_LA : ctenp_pkg::CH_UA) + d - 8'd10;
    endfunction

    // Mostly well-formed lines with random content; some noise, bad digits and erases.
    task automatic send_random_line();
        logic [7:0] body[$];
        logic [7:0] ch;
        logic [1:0] mode;
        int         roll, ndig;
        bit         started;
        mode    = 2'($urandom_range(3, 0));
        roll    = $urandom_range(99, 0);
        started = 1'b0;
        if (roll < 12) begin
            repeat ($urandom_range(6, 1))
                send_char(8'($urandom_range(255, 0)), 2'($urandom_range(3, 0)));
            return;
        end
        repeat ($urandom_range(2, 0)) send_char(rand_blank(), 2'($urandom_range(3, 0)));
        if (mode == ctenp_pkg::CONV_SINGLE) begin
            do ch = 8'($urandom_range(255, 0));
            while (ch == ctenp_pkg::CH_SP || ch == ctenp_pkg::CH_TAB ||
                   ch == ctenp_pkg::CH_CR || ch == ctenp_pkg::CH_LF);
            send_char(ch, ctenp_pkg::CONV_SINGLE);
            return;
        end
        if (roll < 15) begin
            // token that starts with an erase and holds nothing
            body.push_back($urandom_range(1, 0) ? ctenp_pkg::CH_BS : ctenp_pkg::CH_DEL);
        end else begin
            if (mode == ctenp_pkg::CONV_SDEC && $urandom_range(1, 0))
                body.push_back(ctenp_pkg::CH_MINUS);
            if (mode == ctenp_pkg::CONV_HEX && $urandom_range(1, 0)) begin
                body.push_back(ctenp_pkg::CH_ZERO);
                body.push_back($urandom_range(1, 0) ? ctenp_pkg::CH_LX : ctenp_pkg::CH_UX);
            end
            if (roll < 18) ndig = $urandom_range(36, 28);
            else if (roll < 28) ndig = $urandom_range(14, 9);
            else ndig = $urandom_range(9, 1);
            repeat (ndig) body.push_back(rand_digit(mode));
            if ($urandom_range(99, 0) < 8)
                body[$urandom_range(body.size() - 1, 0)] = 8'($urandom_range(126, 32));
        end
        foreach (body[i]) begin
            if ($urandom_range(99, 0) < 8) begin
                send_char(8'($urandom_range(126, 32)), started ? 2'($urandom) : mode);
                started = 1'b1;
                send_char($urandom_range(1, 0) ? ctenp_pkg::CH_BS : ctenp_pkg::CH_DEL,
                          2'($urandom));
            end
            send_char(body[i], started ? 2'($urandom) : mode);
            started = 1'b1;
        end
        send_char($urandom_range(1, 0) ? ctenp_pkg::CH_CR : ctenp_pkg::CH_LF, 2'($urandom));
    endtask

    // result side
    initial begin
        t_line_result got;
        int unsigned  stall;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            stall = $urandom_range(take_gap_max, 0);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = {o_kind, o_echo_char, o_value, o_matched, o_last};
            sb.check_result(got);
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int progress;
        bit pressed;
        push         = 1'b0;
        i_rx_char    = 8'h00;
        i_conversion = ctenp_pkg::CONV_SDEC;
        i_rst_n      = 1'b0;
        pressed      = 1'b0;
        sb           = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines
        send_char(ctenp_pkg::CH_SP, ctenp_pkg::CONV_SINGLE);   // skipped even in single mode
        send_char(8'hFF, ctenp_pkg::CONV_SINGLE);
        send_char(ctenp_pkg::CH_MINUS, ctenp_pkg::CONV_SDEC);  // lone minus
        send_char(ctenp_pkg::CH_CR, ctenp_pkg::CONV_SDEC);
        send_char(ctenp_pkg::CH_BS, ctenp_pkg::CONV_UDEC);     // erase on empty, then junk
        send_char(8'h01, ctenp_pkg::CONV_UDEC);
        send_str("9", ctenp_pkg::CONV_UDEC);
        send_char(ctenp_pkg::CH_DEL, ctenp_pkg::CONV_UDEC);
        send_str("7", ctenp_pkg::CONV_UDEC);
        send_char(ctenp_pkg::CH_LF, ctenp_pkg::CONV_UDEC);
        send_str("0X", ctenp_pkg::CONV_HEX);                  // prefix without digits
        send_char(ctenp_pkg::CH_CR, ctenp_pkg::CONV_HEX);
        send_str("0xfF9", ctenp_pkg::CONV_HEX);
        send_char(ctenp_pkg::CH_LF, ctenp_pkg::CONV_HEX);
        send_char(8'h01, ctenp_pkg::CONV_SDEC);               // empty token
        send_char(ctenp_pkg::CH_CR, ctenp_pkg::CONV_SDEC);
        send_str("1 ~", ctenp_pkg::CONV_UDEC);                // bad digits at printable edges
        send_char(ctenp_pkg::CH_LF, ctenp_pkg::CONV_UDEC);

        while (sb.chars_seen < ITEM_TARGET) begin
            progress = sb.chars_seen;
            if (progress < 120) begin
                send_gap_max = 14;
                take_gap_max = 14;
            end else if (progress < 170) begin
                send_gap_max = 0;
                take_gap_max = 0;
            end else if (progress < 230) begin
                if (!pressed) begin
                    hold_results = 1'b1;
                    pressed      = 1'b1;
                end
                send_gap_max = 0;
                take_gap_max = 14;
            end else if (progress < 320) begin
                send_gap_max = 14;
                take_gap_max = 0;
            end else begin
                send_gap_max = 14;
                take_gap_max = 14;
            end
            send_random_line();
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes (%0d with output), %0d results checked, %0d mismatches",
                 sb.chars_seen, sb.chars_active, sb.results_seen, sb.errors);
        $display("%0d lines parsed (%0d valid), %0d single chars, %0d erases, %0d full drops",
                 sb.lines_done, sb.lines_matched, sb.singles, sb.erases, sb.drops);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/ctenp_pkg.sv
design/ctenp_front.sv
design/ctenp_cmd_q.sv
design/ctenp_back.sv
design/console_token_editor_number_parser.sv
bench/testbench.sv
